/* sv/sls_pkg.sv */
// ----------------------------------------------------------------------------
// Standardized logistic scorer package
// Shared types, constants and the sigmoid breakpoint table.
// ----------------------------------------------------------------------------
`default_nettype none
package sls_pkg;

    localparam int NUM_FEATURES = 8;
    localparam int IDX_W        = 3;
    localparam int SIG_SEGMENTS = 32;
    localparam int SEG_W        = 5;
    localparam int DIV_W        = 49;   // |d| << 16 fits in 49 bits
    localparam int DIV_CNT_W    = 6;

    typedef struct packed {
        logic                action;
        logic [IDX_W-1:0]    feature_index;
        logic signed [31:0]  feature_value;
        logic signed [31:0]  coef_mean;
        logic [30:0]         coef_scale;
        logic signed [31:0]  coef_weight;
        logic                last_feature;
    } t_in_word;

    typedef struct packed {
        logic [15:0]         probability;
        logic signed [47:0]  raw_score;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_SCORE,
        ST_SIG,
        ST_OUT
    } t_state;

    localparam logic ACT_COEF    = 1'b0;
    localparam logic ACT_FEATURE = 1'b1;

    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

    function automatic logic [15:0] sig_point(input logic [5:0] k);
        logic [15:0] v;
        case (k)
            6'd0: v = 16'd22;       6'd1: v = 16'd36;       6'd2: v = 16'd60;
            6'd3: v = 16'd98;       6'd4: v = 16'd162;      6'd5: v = 16'd267;
            6'd6: v = 16'd439;      6'd7: v = 16'd720;      6'd8: v = 16'd1179;
            6'd9: v = 16'd1921;     6'd10: v = 16'd3108;    6'd11: v = 16'd4971;
            6'd12: v = 16'd7812;    6'd13: v = 16'd11955;   6'd14: v = 16'd17625;
            6'd15: v = 16'd24743;   6'd16: v = 16'd32768;   6'd17: v = 16'd40793;
            6'd18: v = 16'd47911;   6'd19: v = 16'd53581;   6'd20: v = 16'd57724;
            6'd21: v = 16'd60565;   6'd22: v = 16'd62428;   6'd23: v = 16'd63615;
            6'd24: v = 16'd64357;   6'd25: v = 16'd64816;   6'd26: v = 16'd65097;
            6'd27: v = 16'd65269;   6'd28: v = 16'd65374;   6'd29: v = 16'd65438;
            6'd30: v = 16'd65476;   6'd31: v = 16'd65500;   6'd32: v = 16'd65514;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* sv/sls_divider.sv */
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 49-bit by 31-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sls_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sls_pkg::DIV_W-1:0]     i_dividend,
    input  wire logic [30:0]                   i_divisor,
    output logic                               o_done,
    output logic [sls_pkg::DIV_W-1:0]          o_quotient
);
    import sls_pkg::*;

    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [31:0]          r_rem, n_rem;
    logic [30:0]          r_div;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic [32:0]          w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem, r_quo[DIV_W-1]} - {2'b00, r_div};
        if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[DIV_W-1]};
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_W - 1);
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= (i_divisor == '0) ? 31'd1 : i_divisor;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_quo  <= n_quo;
            r_rem  <= n_rem;
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = n_quo;
endmodule
`default_nettype wire

/* sv/standardized_logistic_scorer_top.sv */
// ----------------------------------------------------------------------------
// Standardized logistic scorer
// Logistic-regression inference over standardized Q16.16 features.
// ----------------------------------------------------------------------------
// Usage: an input word with action 0 stores mean, scale and weight for one
// feature. An input word with action 1 adds weight*(value-mean)/scale to a
// 48-bit saturating accumulator. When that word carries last_feature, one
// output word follows with the saturated score (bias plus accumulator) and
// its piecewise-linear sigmoid probability, and the accumulator clears.
// Both channels use valid/ready. A coefficient word is stored on acceptance
// and o_in_ready stays high. A feature word holds o_in_ready low while the
// restoring divider produces one quotient bit a cycle, while one 32x32
// multiplier is then used for the two halves of the product, and while
// the accumulator is updated. A last word adds a score step and a sigmoid
// step (the same multiplier again) before its output word is valid. One
// word is processed at a time; o_in_ready is low while busy and while an
// output word waits for the receiver, so a stall holds the block. Reset
// clears the bias register, the accumulator and the sequencer; the
// coefficient tables must be written before use.
`default_nettype none
module standardized_logistic_scorer_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire sls_pkg::t_in_word  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output sls_pkg::t_out_word      o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [31:0]        i_cfg_wdata
);
    import sls_pkg::*;

    t_state r_state, n_state;

    logic signed [31:0] r_mean [NUM_FEATURES];
    logic [30:0]        r_scale [NUM_FEATURES];
    logic signed [31:0] r_weight [NUM_FEATURES];

    logic signed [31:0] r_bias;
    logic signed [47:0] r_acc;
    logic signed [47:0] r_score;
    logic [15:0]        r_prob;
    logic               r_neg, r_last;
    logic [31:0]        r_wmag;
    logic [DIV_W-1:0]   r_quo;
    logic [80:0]        r_prod;
    logic [15:0]        r_lo, r_hi;
    logic [19:0]        r_frac;
    logic               r_sat;

    logic               w_accept, w_div_start, w_div_done;
    logic [DIV_W-1:0]   w_dividend, w_quotient;
    logic signed [32:0] w_diff;
    logic [32:0]        w_dmag;
    logic [IDX_W-1:0]   w_idx;

    // shared multiplier
    logic [31:0]        w_ma, w_mb;
    logic [63:0]        w_mp;

    logic [49:0]        w_mag;
    logic signed [49:0] w_term;
    logic signed [49:0] w_sum;
    logic signed [48:0] w_ssum;
    logic signed [47:0] w_score;
    logic [19:0]        w_off;
    logic [24:0]        w_pos;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_idx       = i_in_data.feature_index;
    assign w_diff      = 33'(i_in_data.feature_value) - 33'(r_mean[w_idx]);
    assign w_dmag      = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_dividend  = {w_dmag[32:0], 16'd0};
    assign w_div_start = w_accept && (i_in_data.action == ACT_FEATURE);

    sls_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_scale[w_idx]),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        case (r_state)
            ST_MUL_LO: begin w_ma = r_wmag; w_mb = r_quo[31:0]; end
            ST_MUL_HI: begin w_ma = r_wmag; w_mb = {15'd0, r_quo[48:32]}; end
            ST_SIG:    begin w_ma = {16'd0, r_hi - r_lo}; w_mb = {12'd0, r_frac}; end
            default:   begin w_ma = '0; w_mb = '0; end
        endcase
    end
    assign w_mp = w_ma * w_mb;

    // term magnitude: product >> 16, capped at 2^48
    assign w_mag  = (r_prod[80:64] != '0) ? 50'h1_0000_0000_0000
                  : ((r_prod[63:16] != '0 && r_prod[80:16] > 65'h1_0000_0000_0000)
                     ? 50'h1_0000_0000_0000 : {2'b00, r_prod[63:16]});
    assign w_term = r_neg ? -$signed(w_mag) : $signed(w_mag);
    assign w_sum  = 50'(r_acc) + w_term;
    assign w_ssum = 49'(r_acc) + 49'(r_bias);
    assign w_score = (w_ssum > 49'(ACC_MAX)) ? ACC_MAX
                   : (w_ssum < 49'(ACC_MIN)) ? ACC_MIN : w_ssum[47:0];

    // Segment position computed from the score being registered.
    assign w_off  = w_score[19:0] + 20'd524288;
    assign w_pos  = {w_off, 5'd0};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_div_start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_MUL_LO;
                end
            end
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_ACC;
            ST_ACC:    n_state = r_last ? ST_SCORE : ST_IDLE;
            ST_SCORE:  n_state = ST_SIG;
            ST_SIG:    n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_out_valid            = (r_state == ST_OUT);
        o_out_data.probability = r_prob;
        o_out_data.raw_score   = r_score;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bias  <= '0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_bias <= i_cfg_wdata;
            end
            if (r_state == ST_ACC) begin
                r_acc <= (w_sum > 50'(ACC_MAX)) ? ACC_MAX
                       : (w_sum < 50'(ACC_MIN)) ? ACC_MIN : w_sum[47:0];
            end
            if (r_state == ST_SCORE) begin
                r_acc <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.action == ACT_COEF) begin
            r_mean[w_idx]   <= i_in_data.coef_mean;
            r_scale[w_idx]  <= i_in_data.coef_scale;
            r_weight[w_idx] <= i_in_data.coef_weight;
        end
        if (w_div_start) begin
            r_last <= i_in_data.last_feature;
            r_neg  <= w_diff[32] ^ r_weight[w_idx][31];
            r_wmag <= r_weight[w_idx][31] ? 32'(-r_weight[w_idx]) : r_weight[w_idx];
        end
        if (w_div_done) begin
            r_quo <= w_quotient;
        end
        case (r_state)
            ST_MUL_LO: r_prod <= {17'd0, w_mp};
            ST_MUL_HI: r_prod <= r_prod + {w_mp[48:0], 32'd0};
            ST_SCORE: begin
                r_score <= w_score;
            end
            ST_SIG: begin
                if (r_sat) begin
                    r_prob <= r_lo;
                end else begin
                    r_prob <= r_lo + w_mp[35:20];
                end
            end
            default: begin
            end
        endcase
        if (r_state == ST_SCORE) begin
            if (w_score < 48'sd0 && w_score < -48'sd524288) begin
                r_sat  <= 1'b1;
                r_frac <= '0;
                r_lo   <= sig_point(6'd0);
                r_hi   <= sig_point(6'd0);
            end else if (w_score >= 48'sd524288) begin
                r_sat  <= 1'b1;
                r_frac <= '0;
                r_lo   <= sig_point(6'd32);
                r_hi   <= sig_point(6'd32);
            end else begin
                r_sat  <= 1'b0;
                r_lo   <= sig_point({1'b0, w_pos[24:20]});
                r_hi   <= sig_point(6'({1'b0, w_pos[24:20]}) + 6'd1);
                r_frac <= w_pos[19:0];
            end
        end
    end
endmodule
`default_nettype wire

/* dv/standardized_logistic_scorer_top_test.sv */
// ----------------------------------------------------------------------------
// Standardized logistic scorer testbench
// Drives coefficient and feature words with random flow control, predicts
// every output word with an independent model and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: holds the predicted state of the scorer and the queue of
// output words that are still owed.
class score_board;
    logic signed [31:0] bias;
    logic signed [31:0] mean_q [8];
    logic [30:0]        scale_q [8];
    logic signed [31:0] weight_q [8];
    logic signed [47:0] acc;
    sls_pkg::t_out_word pending [$];
    int                 errors;

    function new();
        bias = 0;
        acc = 0;
        errors = 0;
    endfunction

    function automatic logic signed [63:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return v;
    endfunction

    // Weighted, standardized contribution of one feature.
    function automatic logic signed [63:0] term_of(input logic signed [31:0] value,
                                                   input int fi);
        logic signed [63:0] d;
        logic [63:0]        dm, n, wm, s;
        logic [127:0]       prod;
        logic [63:0]        mag;
        bit                 neg;
        d = 64'(value) - 64'(mean_q[fi]);
        s = (scale_q[fi] == 0) ? 64'd1 : 64'(scale_q[fi]);
        neg = d < 0;
        dm = neg ? 64'(-d) : 64'(d);
        n = (dm << 16) / s;
        if (weight_q[fi] < 0) neg = !neg;
        wm = (weight_q[fi] < 0) ? 64'(-64'(weight_q[fi])) : 64'(weight_q[fi]);
        if (wm == 0 || n == 0) return 0;
        prod = 128'(wm) * 128'(n);
        mag = (prod[127:64] != 0) ? (64'd1 << 48) : 64'(prod >> 16);
        if (mag > (64'd1 << 48)) mag = 64'd1 << 48;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [15:0] sigmoid(input logic signed [47:0] s);
        logic [15:0] pts [33] = '{22, 36, 60, 98, 162, 267, 439, 720, 1179, 1921,
            3108, 4971, 7812, 11955, 17625, 24743, 32768, 40793, 47911, 53581,
            57724, 60565, 62428, 63615, 64357, 64816, 65097, 65269, 65374, 65438,
            65476, 65500, 65514};
        logic [63:0] pos, frac, seg, p;
        if (s < -48'sd524288) return pts[0];
        if (s >= 48'sd524288) return pts[32];
        pos = 64'(s + 48'sd524288) * 32;
        seg = pos >> 20;
        frac = pos & 64'hF_FFFF;
        p = pts[seg] + (((pts[seg + 1] - pts[seg]) * frac) >> 20);
        return (p > 65535) ? 16'hFFFF : p[15:0];
    endfunction

    function void note_input(input sls_pkg::t_in_word w);
        logic signed [63:0] sc;
        sls_pkg::t_out_word r;
        if (w.action == sls_pkg::ACT_COEF) begin
            mean_q[w.feature_index] = w.coef_mean;
            scale_q[w.feature_index] = w.coef_scale;
            weight_q[w.feature_index] = w.coef_weight;
            return;
        end
        acc = 48'(sat48(64'(acc) + term_of(w.feature_value, w.feature_index)));
        if (w.last_feature) begin
            sc = sat48(64'(acc) + 64'(bias));
            r.raw_score = 48'(sc);
            r.probability = sigmoid(48'(sc));
            pending = {pending, r};
            acc = 0;
        end
    endfunction

    task check_result(input sls_pkg::t_out_word got);
        sls_pkg::t_out_word want;
        if (pending.size() == 0) begin
            report("output word with nothing expected", 0, 0);
            return;
        end
        want = pending.pop_front();
        if (got.raw_score !== want.raw_score)
            report("raw_score", 64'(got.raw_score), 64'(want.raw_score));
        if (got.probability !== want.probability)
            report("probability", 64'(got.probability), 64'(want.probability));
    endtask

    task report(input string what, input logic [63:0] got,
                input logic [63:0] want);
        errors++;
        $display("mismatch: %s got %h expected %h", what, got, want);
    endtask
endclass

module standardized_logistic_scorer_top_test;
    import sls_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_word   in_data;
    logic       out_valid;
    logic       out_ready;
    t_out_word  out_data;
    logic       cfg_we;
    logic [31:0] cfg_wdata;

    score_board sb;
    int  cycle_count;
    bit  quiet_tail;       // no idling on either side in the last part
    bit  hold_receiver;    // long receiver stall in progress
    bit  pend_ok;          // never set or read in this bench

    standardized_logistic_scorer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The cycle limit covers 500 feature words with their idle gaps and
    // stalls on both sides, several times over.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Results are taken at the rising edge where valid and ready meet.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Receiver side: random bursts of back-pressure, a long hold-off when
    // asked for, and a ready that stays high during the quiet tail.
    initial begin
        int n;
        out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_receiver = 1'b0;
                out_ready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 16);
                out_ready <= 1'b0;
                repeat (n) @(negedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one word and hold it until it is accepted; an idle burst may
    // come before it. Valid stays high after acceptance until the next
    // word, an idle burst or a drain replaces it at the same falling edge.
    task automatic send_word(input t_in_word w);
        int n;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        in_data <= w;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!(in_ready === 1'b1));
        sb.note_input(w);
        @(negedge i_clk);
    endtask

    // Wait until every owed output word has arrived, then let the block
    // settle before the bias register is touched.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_bias(input logic [31:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        sb.bias = v;
    endtask

    function automatic logic [31:0] rand_q(input int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
        endcase
    endfunction

    function automatic t_in_word coef_word(input logic [2:0] fi, input logic [31:0] m,
                                           input logic [30:0] s, input logic [31:0] w,
                                           input logic last);
        t_in_word x;
        x = '0;
        x.action = ACT_COEF;
        x.feature_index = fi;
        x.coef_mean = m;
        x.coef_scale = s;
        x.coef_weight = w;
        x.last_feature = last;
        x.feature_value = $urandom();
        return x;
    endfunction

    function automatic t_in_word feat_word(input logic [2:0] fi, input logic [31:0] v,
                                           input logic last);
        t_in_word x;
        x.action = ACT_FEATURE;
        x.feature_index = fi;
        x.feature_value = v;
        x.coef_mean = $urandom();
        x.coef_scale = 31'($urandom());
        x.coef_weight = $urandom();
        x.last_feature = last;
        return x;
    endfunction

    function automatic t_in_word random_coef(input logic [2:0] fi);
        logic [30:0] s;
        case ($urandom_range(0, 3))
            0: s = 31'($urandom());
            1: s = 31'($urandom_range(0, 4));
            2: s = 31'($urandom_range(1 << 14, 1 << 18));
            default: s = 31'h7FFF_FFFF;
        endcase
        return coef_word(fi, rand_q($urandom_range(0, 3)), s,
                         rand_q($urandom_range(0, 3)), $urandom_range(0, 1));
    endfunction

    initial begin
        int k, len, vec;
        sb = new();
        cycle_count = 0;
        quiet_tail = 1'b0;
        hold_receiver = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Every table entry is written before any feature
        // word reads it, and a last mark on a coefficient word must not
        // produce output.
        for (k = 0; k < 8; k++)
            send_word(coef_word(3'(k), 32'h0001_0000 * k, 31'h0001_0000,
                                32'h0000_8000, k[0]));
        send_word(coef_word(3'd7, 32'h8000_0000, 31'd0, 32'h7FFF_FFFF, 1'b0));
        send_word(coef_word(3'd6, 32'h7FFF_FFFF, 31'd0, 32'h8000_0000, 1'b0));
        send_word(coef_word(3'd5, 32'h0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        // Saturate high from both signs of the difference, then a huge score sum.
        send_word(feat_word(3'd7, 32'h7FFF_FFFF, 1'b1));
        send_word(feat_word(3'd6, 32'h8000_0000, 1'b0));
        send_word(feat_word(3'd6, 32'h8000_0000, 1'b1));
        send_word(feat_word(3'd7, 32'h7FFF_FFFF, 1'b0));
        send_word(feat_word(3'd7, 32'h7FFF_FFFF, 1'b1));
        send_word(feat_word(3'd5, 32'h8000_0000, 1'b1));
        // Scores below -8, inside the range and at or above +8.
        send_word(feat_word(3'd1, 32'hFFF0_0000, 1'b1));
        send_word(feat_word(3'd0, 32'h0000_0000, 1'b1));
        send_word(feat_word(3'd0, 32'h0010_0000, 1'b1));
        send_word(feat_word(3'd2, 32'h0012_0000, 1'b1));
        send_word(feat_word(3'd3, 32'h0002_8000, 1'b1));
        drain();
        write_bias(32'h7FFF_FFFF);
        send_word(feat_word(3'd0, 32'h0000_0000, 1'b1));
        drain();
        write_bias(32'h8000_0000);
        send_word(feat_word(3'd0, 32'h0000_0000, 1'b1));
        drain();

        // The receiver stalls for a long stretch while words keep coming.
        hold_receiver = 1'b1;
        for (k = 0; k < 6; k++)
            send_word(feat_word(3'($urandom_range(0, 7)), $urandom(), 1'b1));
        // The sender pauses here until everything owed has come back.
        drain();

        // Random part in phases with different bias settings.
        for (vec = 0; vec < 6; vec++) begin
            case (vec)
                0: write_bias(32'h0);
                1: write_bias(32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh8_0000));
                2: write_bias(32'h7FFF_FFFF);
                3: write_bias(32'h8000_0000);
                default: write_bias($urandom());
            endcase
            if (vec == 5) quiet_tail = 1'b1;
            for (k = 0; k < 16; k++) begin
                if ($urandom_range(0, 9) < 2)
                    send_word(random_coef(3'($urandom_range(0, 7))));
                len = $urandom_range(1, 8);
                while (len > 0) begin
                    // Well-formed vectors with occasional coefficient noise.
                    if ($urandom_range(0, 15) == 0)
                        send_word(random_coef(3'($urandom_range(0, 7))));
                    send_word(feat_word(3'($urandom_range(0, 7)),
                                        rand_q($urandom_range(0, 3)), len == 1));
                    len--;
                end
            end
            drain();
        end

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
sv/sls_pkg.sv
sv/sls_divider.sv
sv/standardized_logistic_scorer_top.sv
dv/standardized_logistic_scorer_top_test.sv
